### rtl/core/sqh_pkg.sv
package sqh_pkg;

  localparam int SCALE_DEPTH_DEF = 16;

  // Field and register widths.
  localparam int LEVEL_W   = 16;
  localparam int SPAN_W    = 15;
  localparam int DIVS_W    = 7;
  localparam int SLEN_W    = 5;
  localparam int EIDX_W    = 4;
  localparam int NOTE_W    = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 15;
  localparam int SIDX_W    = 4;
  localparam int OCT_OUT_W = 8;
  localparam int RES_W     = 24;

  // Register reset values.
  localparam logic [SPAN_W-1:0] SPAN_RST = 15'd2048;
  localparam logic [DIVS_W-1:0] DIVS_RST = 7'd12;

  // Hysteresis is one twentieth of the window, rounded, never below 12 LSB.
  localparam logic [15:0] HYS_DIV   = 16'd20;
  localparam logic [15:0] HYS_ROUND = 16'd10;
  localparam logic [15:0] HYS_MIN   = 16'd12;

  // Octave used for the bounds after a configuration change.
  localparam logic signed [17:0] OCT_INIT = -18'sd10;

  // Serial divider geometry.
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;
  localparam int DIV_CW = 6;

  localparam logic [DIV_CW-1:0] STEPS_CFG  = 6'd16;
  localparam logic [DIV_CW-1:0] STEPS_OCT  = 6'd17;
  localparam logic [DIV_CW-1:0] STEPS_VOLT = 6'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVE_SPAN  = 3'd0,
    CFG_DIVISIONS    = 3'd1,
    CFG_SCALE_LENGTH = 3'd2,
    CFG_ENTRY_INDEX  = 3'd3,
    CFG_ENTRY_VALUE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] steps;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

  localparam logic signed [39:0] S24_MAX40 = 40'sd8388607;
  localparam logic signed [39:0] S24_MIN40 = -40'sd8388608;

  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX40) begin
      r = 24'h7FFFFF;
    end else if (v < S24_MIN40) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/sqh_ram.sv
module sqh_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sqh_div.sv
module sqh_div
  import sqh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  // Restoring division, one quotient bit per cycle. The dividend arrives
  // left aligned so that only the requested number of steps is run.
  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] dvs_r;

  logic [DIV_DW:0]   trial;
  logic              fits;
  logic [DIV_DW-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[DIV_NW-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? DIV_DW'(trial - {1'b0, dvs_r}) : trial[DIV_DW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= req.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NW-2:0], fits};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

### rtl/core/scale_quantizer_hysteresis.sv
// Pitch quantizer with hysteresis for control-voltage samples.
//
// Input channel: in_valid / in_stall / in_level. An item is taken at a clock
// edge with in_valid high and in_stall low. A sample that lies inside the
// current [lower, upper] window is dropped after the window compare and yields no
// result. Any other sample runs through a bit-serial divider three times
// (17, 15 + clog2(SCALE_DEPTH + 1) and 31 steps) plus multiply, lookup and
// bound-update states, and in_stall stays high until the bounds are updated,
// so no new sample is taken before the last one is through. The result shows
// on out_valid and is held in an output register until the receiver takes
// it.
// If out_stall keeps that register full when the next result is ready, the
// block waits with in_stall high.
//
// Configuration writes (cfg_we, cfg_index, cfg_wdata) are taken at once.
// Each valid write restarts the recomputation of offset, window, hysteresis
// and the bounds for octave -10; in_stall is high meanwhile. After reset
// the same pass runs with the reset values.
// Scale entries are stored in a small RAM and must be written before use.
module scale_quantizer_hysteresis
  import sqh_pkg::*;
#(
  parameter int SCALE_DEPTH = SCALE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [LEVEL_W-1:0]   in_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SIDX_W-1:0]           out_scale_index,
  output logic signed [OCT_OUT_W-1:0] out_octave,
  output logic signed [RES_W-1:0]     out_note_number,
  output logic signed [RES_W-1:0]     out_quantized_volts,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DAT_W-1:0]        cfg_wdata
);

  localparam int IXW  = (SCALE_DEPTH > 1) ? $clog2(SCALE_DEPTH) : 1;
  localparam int LENW = $clog2(SCALE_DEPTH + 1);
  localparam int RLW  = SPAN_W + LENW;

  typedef enum logic [24:0] {
    ST_IDLE = 25'b1 << 0,
    ST_CMP  = 25'b1 << 1,
    ST_D1S  = 25'b1 << 2,
    ST_D1W  = 25'b1 << 3,
    ST_ML   = 25'b1 << 4,
    ST_D2S  = 25'b1 << 5,
    ST_D2W  = 25'b1 << 6,
    ST_RD   = 25'b1 << 7,
    ST_NT   = 25'b1 << 8,
    ST_MN   = 25'b1 << 9,
    ST_MO   = 25'b1 << 10,
    ST_MD   = 25'b1 << 11,
    ST_D3S  = 25'b1 << 12,
    ST_D3W  = 25'b1 << 13,
    ST_OUT  = 25'b1 << 14,
    ST_B0   = 25'b1 << 15,
    ST_B1   = 25'b1 << 16,
    ST_B2   = 25'b1 << 17,
    ST_B3   = 25'b1 << 18,
    ST_CHS  = 25'b1 << 19,
    ST_CHW  = 25'b1 << 20,
    ST_CWS  = 25'b1 << 21,
    ST_CWW  = 25'b1 << 22,
    ST_CYS  = 25'b1 << 23,
    ST_CYW  = 25'b1 << 24
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [SPAN_W-1:0] span_r;
  logic [DIVS_W-1:0] divs_r;
  logic [SLEN_W-1:0] slen_r;
  logic [EIDX_W-1:0] eidx_r;
  logic              cfg_hit;

  // Derived settings and bounds.
  logic [15:0]           hdo_r;
  logic [15:0]           win_r;
  logic [15:0]           hys_r;
  logic signed [23:0]    lower_r;
  logic signed [23:0]    upper_r;

  // Per-item working registers.
  logic signed [LEVEL_W-1:0] level_r;
  logic                      xneg_r;
  logic [16:0]               absx_r;
  logic signed [17:0]        oct_r;
  logic [SPAN_W-1:0]         rem_r;
  logic [RLW-1:0]            remlen_r;
  logic [IXW-1:0]            ix_r;
  logic [NOTE_W-1:0]         note_r;
  logic [28:0]               ns_r;
  logic signed [33:0]        os_r;
  logic signed [25:0]        od_r;
  logic [22:0]               q3_r;
  logic [IXW+15:0]           iw_r;
  logic signed [35:0]        ideal_r;

  logic                      out_valid_r;
  logic [SIDX_W-1:0]         out_sidx_r;
  logic signed [OCT_OUT_W-1:0] out_oct_r;
  logic signed [RES_W-1:0]   out_nn_r;
  logic signed [RES_W-1:0]   out_volts_r;

  logic [SPAN_W-1:0] span_e;
  logic [DIVS_W-1:0] divs_e;
  logic [DIVS_W-1:0] len_raw;
  logic [LENW-1:0]   len_e;

  logic signed [17:0] xs;
  logic               in_window;
  logic               out_free;
  logic [NOTE_W-1:0]  tbl_rdata;
  logic               tbl_we;
  logic [30:0]        vnum;
  logic [RLW-1:0]     q2;
  logic [SPAN_W-1:0]  r1;
  logic [17:0]        q1_ext;
  logic               r1_nz;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Zero span and zero divisions behave as one; the scale length falls back
  // to the division count in chromatic mode and never exceeds the table.
  assign span_e  = (span_r == '0) ? SPAN_W'(1) : span_r;
  assign divs_e  = (divs_r == '0) ? DIVS_W'(1) : divs_r;
  assign len_raw = (slen_r == '0) ? divs_e : DIVS_W'(slen_r);
  assign len_e   = (32'(len_raw) > SCALE_DEPTH) ? LENW'(SCALE_DEPTH) : LENW'(len_raw);

  assign xs     = 18'(level_r) + $signed({2'b00, hdo_r});
  assign in_window = (24'(level_r) <= upper_r) && (24'(level_r) >= lower_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign vnum   = {1'b0, ns_r, 1'b0} + 31'({divs_e, 8'b0});
  assign q2     = div_rsp.quotient[RLW-1:0];
  assign r1     = div_rsp.remainder[SPAN_W-1:0];
  assign q1_ext = {1'b0, div_rsp.quotient[16:0]};
  assign r1_nz  = (r1 != '0);

  assign cfg_hit = cfg_we && (cfg_index <= CFG_ENTRY_VALUE);
  assign tbl_we  = cfg_we && (cfg_index == CFG_ENTRY_VALUE) && (32'(eidx_r) < SCALE_DEPTH);

  sqh_ram #(
    .WIDTH(NOTE_W),
    .DEPTH(SCALE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(IXW'(eidx_r)),
    .wdata(cfg_wdata[NOTE_W-1:0]),
    .raddr(ix_r),
    .rdata(tbl_rdata)
  );

  sqh_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // The divider is shared by all six divisions; its operands are picked by
  // the start state and left aligned to the step count.
  always_comb begin
    div_req = '0;
    unique case (state_r)
      ST_D1S: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_OCT;
        div_req.dividend = {absx_r, 15'b0};
        div_req.divisor  = DIV_DW'(span_e);
      end
      ST_D2S: begin
        div_req.start    = 1'b1;
        div_req.steps    = DIV_CW'(RLW);
        div_req.dividend = {remlen_r, {(DIV_NW-RLW){1'b0}}};
        div_req.divisor  = DIV_DW'(span_e);
      end
      ST_D3S: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_VOLT;
        div_req.dividend = {vnum, 1'b0};
        div_req.divisor  = {divs_e, 9'b0};
      end
      ST_CHS: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_CFG;
        div_req.dividend = {16'(span_e) + 16'(divs_e), 16'b0};
        div_req.divisor  = DIV_DW'({divs_e, 1'b0});
      end
      ST_CWS: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_CFG;
        div_req.dividend = {16'(span_e) + 16'(len_e >> 1), 16'b0};
        div_req.divisor  = DIV_DW'(len_e);
      end
      ST_CYS: begin
        div_req.start    = 1'b1;
        div_req.steps    = STEPS_CFG;
        div_req.dividend = {win_r + HYS_ROUND, 16'b0};
        div_req.divisor  = HYS_DIV;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = in_window ? ST_IDLE : ST_D1S;
      ST_D1S:  state_nxt = ST_D1W;
      ST_D1W:  if (div_rsp.done) state_nxt = ST_ML;
      ST_ML:   state_nxt = ST_D2S;
      ST_D2S:  state_nxt = ST_D2W;
      ST_D2W:  if (div_rsp.done) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_NT;
      ST_NT:   state_nxt = ST_MN;
      ST_MN:   state_nxt = ST_MO;
      ST_MO:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_D3S;
      ST_D3S:  state_nxt = ST_D3W;
      ST_D3W:  if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_B0;
      ST_B0:   state_nxt = ST_B1;
      ST_B1:   state_nxt = ST_B2;
      ST_B2:   state_nxt = ST_B3;
      ST_B3:   state_nxt = ST_IDLE;
      ST_CHS:  state_nxt = ST_CHW;
      ST_CHW:  if (div_rsp.done) state_nxt = ST_CWS;
      ST_CWS:  state_nxt = ST_CWW;
      ST_CWW:  if (div_rsp.done) state_nxt = ST_CYS;
      ST_CYS:  state_nxt = ST_CYW;
      ST_CYW:  if (div_rsp.done) state_nxt = ST_B0;
      default: state_nxt = ST_CHS;
    endcase
    // Any register write restarts the settings pass from the top.
    if (cfg_hit) begin
      state_nxt = ST_CHS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CHS;
      out_valid_r <= 1'b0;
      span_r      <= SPAN_RST;
      divs_r      <= DIVS_RST;
      slen_r      <= '0;
      eidx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OCTAVE_SPAN:  span_r <= cfg_wdata[SPAN_W-1:0];
          CFG_DIVISIONS:    divs_r <= cfg_wdata[DIVS_W-1:0];
          CFG_SCALE_LENGTH: slen_r <= cfg_wdata[SLEN_W-1:0];
          CFG_ENTRY_INDEX:  eidx_r <= cfg_wdata[EIDX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r) inside
      ST_IDLE: if (in_valid) level_r <= in_level;
      ST_CMP: begin
        xneg_r <= xs[17];
        absx_r <= xs[17] ? 17'(-xs) : xs[16:0];
      end
      ST_D1W: if (div_rsp.done) begin
        // Floor division: a negative sum with a remainder rounds one more
        // octave down and takes the complementary remainder.
        if (xneg_r) begin
          oct_r <= -$signed(q1_ext + 18'(r1_nz));
          rem_r <= r1_nz ? span_e - r1 : '0;
        end else begin
          oct_r <= $signed(q1_ext);
          rem_r <= r1;
        end
      end
      ST_ML: remlen_r <= RLW'(rem_r) * RLW'(len_e);
      ST_D2W: if (div_rsp.done) begin
        ix_r <= (q2 >= RLW'(len_e)) ? IXW'(len_e - 1'b1) : IXW'(q2);
      end
      ST_NT:  note_r <= (slen_r == '0) ? NOTE_W'({ix_r, 8'b0}) : tbl_rdata;
      ST_MN:  ns_r <= 29'(note_r) * 29'(span_e);
      ST_MO, ST_B0: os_r <= 34'(oct_r) * 34'($signed({1'b0, span_e}));
      ST_MD:  od_r <= 26'(oct_r) * 26'($signed({1'b0, divs_e}));
      ST_D3W: if (div_rsp.done) q3_r <= div_rsp.quotient[22:0];
      ST_OUT: if (out_free) begin
        out_sidx_r  <= SIDX_W'(ix_r);
        if (oct_r > 18'sd127) begin
          out_oct_r <= 8'sd127;
        end else if (oct_r < -18'sd128) begin
          out_oct_r <= -8'sd128;
        end else begin
          out_oct_r <= oct_r[7:0];
        end
        out_nn_r    <= sat24($signed({26'b0, note_r}) + 40'($signed({od_r, 8'b0})));
        out_volts_r <= sat24($signed({17'b0, q3_r}) + 40'(os_r));
      end
      ST_B1:  iw_r <= (IXW+16)'(ix_r) * (IXW+16)'(win_r);
      ST_B2:  ideal_r <= 36'(os_r) + $signed({{(20-IXW){1'b0}}, iw_r})
                         - $signed({20'b0, hdo_r});
      ST_B3: begin
        lower_r <= sat24(40'(ideal_r - $signed({20'b0, hys_r})));
        upper_r <= sat24(40'(ideal_r + $signed({20'b0, hys_r}) + $signed({20'b0, win_r})));
      end
      ST_CHW: if (div_rsp.done) hdo_r <= div_rsp.quotient[15:0];
      ST_CWW: if (div_rsp.done) win_r <= div_rsp.quotient[15:0];
      ST_CYW: if (div_rsp.done) begin
        hys_r <= (div_rsp.quotient[15:0] < HYS_MIN) ? HYS_MIN : div_rsp.quotient[15:0];
        oct_r <= OCT_INIT;
        ix_r  <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_scale_index     = out_sidx_r;
  assign out_octave          = out_oct_r;
  assign out_note_number     = out_nn_r;
  assign out_quantized_volts = out_volts_r;

  // The window is never inverted once the bounds are in use.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (lower_r <= upper_r))
    else $error("hysteresis window inverted");

  // A result is only ever loaded from the output state.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside output state");

  // The selected entry lies within the effective scale length.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NT) |-> (LENW'(ix_r) < len_e))
    else $error("scale index beyond scale length");

endmodule
